@@ rtl/wpf_pkg.sv @@
// Shared types and constants for the waypoint follower.
// No dependencies; imported by every rtl module.
`default_nettype none
package wpf_pkg;
    localparam int MAX_POINTS = 16;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = 5;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_SETP = 2'd2;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_SPEED  = 2'd2;
    localparam logic [1:0] REG_THRESH = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        delta_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [3:0]         target_slot;
        logic               arrived;
        logic               stepped;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture input item
        logic load_wp;   // write waypoint slot
        logic set_pos;   // write position
        logic rd_wp;     // read target waypoint
        logic diff;      // form deltas
        logic sq_start;  // clear sum and sqrt state
        logic sq_acc;    // add one axis square
        logic sq_step;
        logic arrive;    // advance target
        logic div_start; // start axis division
        logic div_step;
        logic div_done;  // commit axis, go next
        logic commit;    // commit position
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic active;    // enable and count >= 2
        logic is_tick;
        logic is_load;
        logic is_set;
        logic sq_last;
        logic near;      // arrival
        logic div_last;
        logic axis_last;
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/waypoint_follower.sv @@
// Waypoint follower: one item at a time, one result per item.
// Load/set/idle ticks give their result without the sqrt; an arriving tick adds the
// axis squares and a 34-step sqrt, and a moving tick adds three axis divisions.
// Next item is taken with the result transfer.
// Synchronous active-low reset: position and target zero, registers default.
// Waypoint memory has no reset.
`default_nettype none
module waypoint_follower (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire wpf_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output wpf_pkg::t_out     o_data,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [20:0]  i_cfg_data
);
    import wpf_pkg::*;
    t_cmd cmd;
    t_stat stat;

    wpf_ctrl u_ctrl (.i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_stat(stat), .o_cmd(cmd));
    wpf_dp u_dp (.i_clk, .i_rst_n, .i_item(i_data), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .i_cmd(cmd), .o_stat(stat), .o_res(o_data));
endmodule
`default_nettype wire

@@ rtl/wpf_ctrl.sv @@
// Controller state machine of the waypoint follower.
// Depends on wpf_pkg.
`default_nettype none
module wpf_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  wire logic         i_stall,
    input  wire wpf_pkg::t_stat i_stat,
    output wpf_pkg::t_cmd     o_cmd
);
    import wpf_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RD = 4'd2, S_DIFF = 4'd3,
        S_SQS = 4'd4, S_SQ = 4'd5, S_CHK = 4'd6, S_DVS = 4'd7, S_DV = 4'd8,
        S_DVE = 4'd9, S_COM = 4'd10, S_OUT = 4'd11;
    logic [3:0] r_st, n_st;
    logic r_ov, n_ov;

    assign o_valid = r_ov;
    // new item only when idle and the result slot is free or draining
    assign o_stall = (r_st != S_IDLE) || (r_ov && i_stall);

    always_comb begin
        n_st = r_st;
        n_ov = r_ov && i_stall;
        o_cmd = '0;
        case (r_st)
            S_IDLE: if (i_valid && !o_stall) begin
                o_cmd.latch = 1'b1;
                n_st = S_DEC;
            end
            S_DEC: begin
                if (i_stat.is_load) o_cmd.load_wp = 1'b1;
                if (i_stat.is_set) o_cmd.set_pos = 1'b1;
                n_st = (i_stat.is_tick && i_stat.active) ? S_RD : S_OUT;
                o_cmd.rd_wp = i_stat.is_tick && i_stat.active;
            end
            S_RD: begin o_cmd.diff = 1'b1; n_st = S_DIFF; end
            S_DIFF: begin o_cmd.sq_start = 1'b1; n_st = S_SQS; end
            // one axis square per cycle, x then y then z
            S_SQS: begin
                o_cmd.sq_acc = 1'b1;
                if (i_stat.axis_last) n_st = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_stat.sq_last) n_st = S_CHK;
            end
            S_CHK: begin
                if (i_stat.near) begin
                    o_cmd.arrive = 1'b1;
                    n_st = S_OUT;
                end else begin
                    n_st = S_DVS;
                end
            end
            S_DVS: begin o_cmd.div_start = 1'b1; n_st = S_DV; end
            S_DV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_st = S_DVE;
            end
            S_DVE: begin
                o_cmd.div_done = 1'b1;
                n_st = i_stat.axis_last ? S_COM : S_DVS;
            end
            S_COM: begin o_cmd.commit = 1'b1; n_st = S_OUT; end
            S_OUT: begin n_ov = 1'b1; n_st = S_IDLE; end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end
endmodule
`default_nettype wire

@@ rtl/wpf_dp.sv @@
// Datapath: waypoint memory, position, iterative sqrt and divider.
// Depends on wpf_pkg.
`default_nettype none
module wpf_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire wpf_pkg::t_in   i_item,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [20:0]    i_cfg_data,
    input  wire wpf_pkg::t_cmd  i_cmd,
    output wpf_pkg::t_stat      o_stat,
    output wpf_pkg::t_out       o_res
);
    import wpf_pkg::*;
    logic r_en;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0] r_spd;
    logic [20:0] r_thr;
    t_in r_it;
    logic signed [31:0] r_px, r_py, r_pz, r_nx, r_ny, r_nz;
    logic [IDX_W-1:0] r_tgt, r_t;
    logic r_arr, r_stp;
    logic signed [31:0] r_mx [MAX_POINTS];
    logic signed [31:0] r_my [MAX_POINTS];
    logic signed [31:0] r_mz [MAX_POINTS];
    logic signed [31:0] r_wx, r_wy, r_wz;
    logic signed [32:0] r_dx, r_dy, r_dz;
    // sqrt: bit-serial restoring, one result bit per cycle
    logic [65:0] r_rem;
    logic [33:0] r_root;
    logic [5:0] r_sqc;
    // divide: |d|*step / dist, restoring, one quotient bit per cycle
    logic [63:0] r_num, r_q;
    logic [33:0] r_den;
    logic [34:0] r_drem;
    logic [5:0] r_dvc;
    logic [1:0] r_ax;
    logic [23:0] r_step;

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] t_nxt;
    logic signed [32:0] d_sel;
    logic signed [31:0] p_sel;
    logic [32:0] mag_d;
    logic [33:0] one_m;
    logic [66:0] trial;
    logic [34:0] drem_sh;
    logic signed [34:0] nsum;
    logic signed [31:0] sat;

    assign cnt = (r_cnt > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_cnt;
    assign o_stat.is_tick = r_it.cmd == CMD_TICK;
    assign o_stat.is_load = r_it.cmd == CMD_LOAD;
    assign o_stat.is_set  = r_it.cmd == CMD_SETP;
    assign o_stat.active = r_en && (cnt >= CNT_W'(2));
    assign o_stat.sq_last = r_sqc == 6'd0;
    assign o_stat.near = (r_root == '0) || (r_root < 34'(r_thr));
    assign o_stat.div_last = r_dvc == 6'd0;
    assign o_stat.axis_last = r_ax == 2'd2;

    assign t_nxt = CNT_W'(r_t) + CNT_W'(1);
    assign one_m = 34'd1 << r_sqc;
    // (root + 2^b)^2 - root^2 = (2*root + 2^b) * 2^b; reaches 2^66 at the top bit
    assign trial = ({32'd0, r_root, 1'b0} + {33'd0, one_m}) << r_sqc;
    assign drem_sh = {r_drem[33:0], r_num[63]};

    always_comb begin
        case (r_ax)
            2'd0: begin d_sel = r_dx; p_sel = r_px; end
            2'd1: begin d_sel = r_dy; p_sel = r_py; end
            default: begin d_sel = r_dz; p_sel = r_pz; end
        endcase
        mag_d = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
        nsum = d_sel[32] ? (35'(p_sel) - $signed({2'b0, r_q[32:0]}))
                         : (35'(p_sel) + $signed({2'b0, r_q[32:0]}));
        // a step of 2^33 or more always saturates
        if (r_q[63:33] != '0)
            nsum = d_sel[32] ? -35'sd4294967296 : 35'sd4294967296;
        if (nsum > 35'sd2147483647) sat = 32'sh7FFFFFFF;
        else if (nsum < -35'sd2147483648) sat = 32'sh80000000;
        else sat = nsum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wp) begin
            r_mx[r_it.point_index[IDX_W-1:0]] <= r_it.coord_x;
            r_my[r_it.point_index[IDX_W-1:0]] <= r_it.coord_y;
            r_mz[r_it.point_index[IDX_W-1:0]] <= r_it.coord_z;
        end
        if (i_cmd.rd_wp) begin
            r_wx <= r_mx[(CNT_W'(r_tgt) < cnt) ? r_tgt : '0];
            r_wy <= r_my[(CNT_W'(r_tgt) < cnt) ? r_tgt : '0];
            r_wz <= r_mz[(CNT_W'(r_tgt) < cnt) ? r_tgt : '0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b1; r_cnt <= '0; r_spd <= 16'd384; r_thr <= 21'd3277;
            r_px <= '0; r_py <= '0; r_pz <= '0; r_tgt <= '0;
            r_arr <= 1'b0; r_stp <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ENABLE: r_en <= i_cfg_data[0];
                    REG_COUNT:  r_cnt <= i_cfg_data[CNT_W-1:0];
                    REG_SPEED:  r_spd <= i_cfg_data[15:0];
                    REG_THRESH: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.latch) begin r_arr <= 1'b0; r_stp <= 1'b0; end
            if (i_cmd.set_pos) begin
                r_px <= r_it.coord_x; r_py <= r_it.coord_y; r_pz <= r_it.coord_z;
            end
            if (i_cmd.rd_wp) r_t <= (CNT_W'(r_tgt) < cnt) ? r_tgt : '0;
            if (i_cmd.diff) r_tgt <= r_t;
            if (i_cmd.arrive) begin
                r_tgt <= (t_nxt >= cnt) ? '0 : t_nxt[IDX_W-1:0];
                r_arr <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_px <= r_nx; r_py <= r_ny; r_pz <= r_nz; r_stp <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_it <= i_item;
        if (i_cmd.diff) begin
            r_dx <= 33'(r_wx) - 33'(r_px);
            r_dy <= 33'(r_wy) - 33'(r_py);
            r_dz <= 33'(r_wz) - 33'(r_pz);
            r_step <= 24'((32'(r_spd) * 32'(r_it.delta_time)) >> 8);
        end
        if (i_cmd.sq_start) begin
            r_rem <= '0; r_root <= '0; r_sqc <= 6'd33;
            r_nx <= r_px; r_ny <= r_py; r_nz <= r_pz; r_ax <= 2'd0;
        end
        // the three axis squares share one multiplier; axis wraps for the divides
        if (i_cmd.sq_acc) begin
            r_rem <= r_rem + 66'(mag_d * mag_d);
            r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
        end
        if (i_cmd.sq_step) begin
            if (trial <= {1'b0, r_rem}) begin
                r_rem <= r_rem - trial[65:0];
                r_root <= r_root | one_m;
            end
            r_sqc <= r_sqc - 6'd1;
        end
        if (i_cmd.div_start) begin
            r_num <= 64'(mag_d) * 64'(r_step);
            r_den <= r_root; r_drem <= '0; r_q <= '0; r_dvc <= 6'd63;
        end
        if (i_cmd.div_step) begin
            if (drem_sh >= {1'b0, r_den}) begin
                r_drem <= drem_sh - {1'b0, r_den};
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_drem <= drem_sh;
                r_q <= {r_q[62:0], 1'b0};
            end
            r_num <= {r_num[62:0], 1'b0};
            r_dvc <= r_dvc - 6'd1;
        end
        if (i_cmd.div_done) begin
            case (r_ax)
                2'd0: r_nx <= sat;
                2'd1: r_ny <= sat;
                default: r_nz <= sat;
            endcase
            r_ax <= r_ax + 2'd1;
        end
    end

    assign o_res.pos_x = r_px;
    assign o_res.pos_y = r_py;
    assign o_res.pos_z = r_pz;
    assign o_res.target_slot = 4'(r_tgt);
    assign o_res.arrived = r_arr;
    assign o_res.stepped = r_stp;
endmodule
`default_nettype wire

@@ rtl/wpf_check.sv @@
// Port-level checks for the waypoint follower, bound to the top level.
// Depends on wpf_pkg.
`default_nettype none
module wpf_check (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_valid,
    input wire logic         o_stall,
    input wire logic         o_valid,
    input wire logic         i_stall,
    input wire wpf_pkg::t_out o_data
);
    import wpf_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("out hold");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_data.arrived && o_data.stepped)) else $error("arrived and stepped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("two in flight");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule
bind waypoint_follower wpf_check u_check (.i_clk, .i_rst_n, .i_valid, .o_stall,
    .o_valid, .i_stall, .o_data);
`default_nettype wire
